// ===== rtl/core/hrhp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_pkg
// Types, character codes, scan codes and helpers for the HTTP request head
// parser.
// ----------------------------------------------------------------------------
package hrhp_pkg;

	localparam int LEN_BITS = 32;
	localparam int OUT_BITS = 32;
	localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;

	localparam logic [4:0] KEY_LEN  = 5'd14;
	localparam logic [4:0] KEY_FAIL = 5'd31;

	// request line scan codes
	localparam logic [3:0] R_LEAD     = 4'd0;
	localparam logic [3:0] R_METHOD   = 4'd1;
	localparam logic [3:0] R_AFTER    = 4'd2;
	localparam logic [3:0] R_SKIP     = 4'd3;
	localparam logic [3:0] R_PATH_OK  = 4'd4;
	localparam logic [3:0] R_PATH_BAD = 4'd5;

	// header line scan codes
	localparam logic [3:0] H_START   = 4'd0;
	localparam logic [3:0] H_COLONS  = 4'd1;
	localparam logic [3:0] H_KEYLEAD = 4'd2;
	localparam logic [3:0] H_KEY     = 4'd3;
	localparam logic [3:0] H_KEYTAIL = 4'd4;
	localparam logic [3:0] H_VALNEED = 4'd5;
	localparam logic [3:0] H_VALWS   = 4'd6;
	localparam logic [3:0] H_VALSIGN = 4'd7;
	localparam logic [3:0] H_VALDIG  = 4'd8;
	localparam logic [3:0] H_VALDONE = 4'd9;

	typedef enum logic [1:0] {
		PH_REQ  = 2'd0,
		PH_HDR  = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_PENDING  = 2'd0,
		ST_COMPLETE = 2'd1,
		ST_MALFORM  = 2'd2,
		ST_WEDGED   = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       drop_request;
	} item_t;

	typedef struct packed {
		status_t             status;
		phase_t              phase;
		logic [OUT_BITS-1:0] content_length;
		logic                body_byte;
	} result_t;

	function automatic logic [7:0] key_char(input logic [3:0] pos);
		logic [7:0] c;
		unique case (pos)
			4'd0:    c = 8'h43; // C
			4'd1:    c = 8'h6F; // o
			4'd2:    c = 8'h6E; // n
			4'd3:    c = 8'h74; // t
			4'd4:    c = 8'h65; // e
			4'd5:    c = 8'h6E; // n
			4'd6:    c = 8'h74; // t
			4'd7:    c = 8'h2D; // -
			4'd8:    c = 8'h4C; // L
			4'd9:    c = 8'h65; // e
			4'd10:   c = 8'h6E; // n
			4'd11:   c = 8'h67; // g
			4'd12:   c = 8'h74; // t
			4'd13:   c = 8'h68; // h
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_ws(input logic [7:0] b);
		return (b != CH_NUL) && (b <= CH_SPACE);
	endfunction

	function automatic logic is_delim(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	function automatic logic [OUT_BITS-1:0] to_out(input logic [LEN_BITS-1:0] v);
		logic [63:0] wide;
		wide = 64'(v);
		return wide[OUT_BITS-1:0];
	endfunction

endpackage

// ===== rtl/core/http_request_head_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_head_parser
// Byte-wise HTTP/1.x request head checker with Content-Length body count.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | data_byte, drop_request
//  out     | out_valid / out_stall| status, phase, content_length, body_byte
//
//  One byte per cycle while the output does not stall; a taken byte's result
//  passes through the input register, then the result register.
//  The parser state updates as a byte moves from the input register into
//  the result register.
//  arst_n clears all parser state to the start of a request line.
//  A stalled output holds the result and, once the input register is full,
//  stalls the input.
// ----------------------------------------------------------------------------
module http_request_head_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    data_byte,
	input  logic                          drop_request,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    status,
	output logic [1:0]                    phase,
	output logic [hrhp_pkg::OUT_BITS-1:0] content_length,
	output logic                          body_byte
);

	hrhp_pkg::item_t   item, item_s1;
	hrhp_pkg::result_t result, result_q;
	logic              valid_s1;
	logic              out_free;
	logic              fire;

	assign item.data_byte    = data_byte;
	assign item.drop_request = drop_request;
	assign fire              = valid_s1 && out_free;
	assign in_stall          = valid_s1 && !out_free;

	hrhp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item     (item),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	hrhp_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (fire),
		.item_s1 (item_s1),
		.result  (result)
	);

	hrhp_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.result    (result),
		.out_stall (out_stall),
		.out_free  (out_free),
		.out_valid (out_valid),
		.result_q  (result_q)
	);

	assign status         = result_q.status;
	assign phase          = result_q.phase;
	assign content_length = result_q.content_length;
	assign body_byte      = result_q.body_byte;

endmodule

// ===== rtl/core/hrhp_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_in_stage
// Input register: captures one item whenever the stage is not stalled.
// ----------------------------------------------------------------------------
module hrhp_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_stall,
	input  hrhp_pkg::item_t item,
	output logic           valid_s1,
	output hrhp_pkg::item_t item_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= item;
		end
	end

endmodule

// ===== rtl/core/hrhp_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_step
// Parser state and the per-byte update: line scan, key match, decimal value
// accumulation, body count and fault tracking.
// ----------------------------------------------------------------------------
module hrhp_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  hrhp_pkg::item_t   item_s1,
	output hrhp_pkg::result_t result
);

	localparam int LB = hrhp_pkg::LEN_BITS;

	hrhp_pkg::phase_t phase_q, phase_n;
	logic [1:0]       fault_q, fault_n;
	logic [3:0]       scan_q, scan_n;
	logic [3:0]       scan_prev_q, scan_prev_n;
	logic             prev_cr_q, prev_cr_n;
	logic [4:0]       key_pos_q, key_pos_n;
	logic [LB-1:0]    accum_q, accum_n;
	logic             neg_q, neg_n;
	logic [LB-1:0]    length_q, length_n;
	logic [LB-1:0]    body_cnt_q, body_cnt_n;

	logic [7:0]       b;
	logic [LB-1:0]    body_inc;
	logic [LB+3:0]    accum_x10;
	logic [4:0]       key_step;
	logic [3:0]       req_scan;

	assign b         = item_s1.data_byte;
	assign body_inc  = (body_cnt_q < hrhp_pkg::LEN_MAX) ? body_cnt_q + 1'b1 : body_cnt_q;
	assign accum_x10 = ({4'b0, accum_q} << 3) + ({4'b0, accum_q} << 1) + (LB + 4)'(b[3:0]);
	assign key_step  = ((key_pos_q < hrhp_pkg::KEY_LEN)
		&& (b == hrhp_pkg::key_char(key_pos_q[3:0]))) ? key_pos_q + 1'b1 : hrhp_pkg::KEY_FAIL;

	always_comb begin
		unique case (scan_q)
			hrhp_pkg::R_LEAD:
				req_scan = hrhp_pkg::is_delim(b) ? hrhp_pkg::R_LEAD : hrhp_pkg::R_METHOD;
			hrhp_pkg::R_METHOD:
				req_scan = hrhp_pkg::is_delim(b) ? hrhp_pkg::R_AFTER : hrhp_pkg::R_METHOD;
			hrhp_pkg::R_AFTER, hrhp_pkg::R_SKIP: begin
				if (hrhp_pkg::is_delim(b))
					req_scan = hrhp_pkg::R_SKIP;
				else if (b == hrhp_pkg::CH_SLASH)
					req_scan = hrhp_pkg::R_PATH_OK;
				else
					req_scan = hrhp_pkg::R_PATH_BAD;
			end
			hrhp_pkg::R_PATH_OK:
				req_scan = hrhp_pkg::R_PATH_OK;
			default:
				req_scan = hrhp_pkg::R_PATH_BAD;
		endcase
	end

	always_comb begin
		phase_n     = phase_q;
		fault_n     = fault_q;
		scan_n      = scan_q;
		scan_prev_n = scan_prev_q;
		prev_cr_n   = prev_cr_q;
		key_pos_n   = key_pos_q;
		accum_n     = accum_q;
		neg_n       = neg_q;
		length_n    = length_q;
		body_cnt_n  = body_cnt_q;

		result.status         = hrhp_pkg::ST_PENDING;
		result.phase          = phase_q;
		result.content_length = hrhp_pkg::to_out(length_q);
		result.body_byte      = 1'b0;

		priority if (item_s1.drop_request) begin
			phase_n     = hrhp_pkg::PH_REQ;
			fault_n     = 2'd0;
			scan_n      = 4'd0;
			scan_prev_n = 4'd0;
			prev_cr_n   = 1'b0;
			key_pos_n   = 5'd0;
			accum_n     = '0;
			neg_n       = 1'b0;
			length_n    = '0;
			body_cnt_n  = '0;
			result.phase          = hrhp_pkg::PH_REQ;
			result.content_length = '0;
		end else if (fault_q != 2'd0) begin
			result.status = hrhp_pkg::status_t'(fault_q);
		end else if (phase_q == hrhp_pkg::PH_BODY) begin
			result.body_byte = 1'b1;
			if (body_inc >= length_q) begin
				phase_n     = hrhp_pkg::PH_REQ;
				scan_n      = 4'd0;
				scan_prev_n = 4'd0;
				prev_cr_n   = 1'b0;
				key_pos_n   = 5'd0;
				accum_n     = '0;
				neg_n       = 1'b0;
				length_n    = '0;
				body_cnt_n  = '0;
				result.status = hrhp_pkg::ST_COMPLETE;
				result.phase  = hrhp_pkg::PH_REQ;
			end else begin
				body_cnt_n = body_inc;
			end
		end else if (b == hrhp_pkg::CH_NUL) begin
			fault_n       = 2'(hrhp_pkg::ST_WEDGED);
			result.status = hrhp_pkg::ST_WEDGED;
		end else if (b == hrhp_pkg::CH_LF) begin
			priority if (!prev_cr_q) begin
				fault_n = 2'(hrhp_pkg::ST_MALFORM);
			end else if (phase_q == hrhp_pkg::PH_REQ) begin
				if (scan_prev_q == hrhp_pkg::R_PATH_OK)
					phase_n = hrhp_pkg::PH_HDR;
				else
					fault_n = 2'(hrhp_pkg::ST_MALFORM);
			end else if (scan_prev_q == hrhp_pkg::H_START) begin
				phase_n    = hrhp_pkg::PH_BODY;
				body_cnt_n = '0;
			end else if (scan_prev_q >= hrhp_pkg::H_VALWS
				&& scan_prev_q <= hrhp_pkg::H_VALDONE) begin
				if (key_pos_q == hrhp_pkg::KEY_LEN)
					length_n = neg_q ? '0 : accum_q;
			end else begin
				fault_n = 2'(hrhp_pkg::ST_MALFORM);
			end

			if (fault_n != 2'd0) begin
				result.status = hrhp_pkg::status_t'(fault_n);
			end else begin
				scan_n      = 4'd0;
				scan_prev_n = 4'd0;
				prev_cr_n   = 1'b0;
				key_pos_n   = 5'd0;
				accum_n     = '0;
				neg_n       = 1'b0;
				if (phase_n == hrhp_pkg::PH_BODY && length_n == '0) begin
					phase_n       = hrhp_pkg::PH_REQ;
					length_n      = '0;
					body_cnt_n    = '0;
					result.status = hrhp_pkg::ST_COMPLETE;
					result.phase  = hrhp_pkg::PH_REQ;
				end else begin
					result.phase          = phase_n;
					result.content_length = hrhp_pkg::to_out(length_n);
				end
			end
		end else begin
			scan_prev_n = scan_q;
			prev_cr_n   = (b == hrhp_pkg::CH_CR);
			if (phase_q == hrhp_pkg::PH_REQ) begin
				scan_n = req_scan;
			end else begin
				unique case (scan_q)
					hrhp_pkg::H_START, hrhp_pkg::H_COLONS: begin
						priority if (b == hrhp_pkg::CH_COLON) begin
							scan_n = hrhp_pkg::H_COLONS;
						end else if (hrhp_pkg::is_ws(b)) begin
							scan_n = hrhp_pkg::H_KEYLEAD;
						end else begin
							key_pos_n = key_step;
							scan_n    = hrhp_pkg::H_KEY;
						end
					end
					hrhp_pkg::H_KEYLEAD, hrhp_pkg::H_KEY, hrhp_pkg::H_KEYTAIL: begin
						priority if (b == hrhp_pkg::CH_COLON) begin
							scan_n = hrhp_pkg::H_VALNEED;
						end else if (hrhp_pkg::is_ws(b)) begin
							scan_n = (scan_q == hrhp_pkg::H_KEYLEAD) ?
								hrhp_pkg::H_KEYLEAD : hrhp_pkg::H_KEYTAIL;
						end else begin
							key_pos_n = (scan_q == hrhp_pkg::H_KEYTAIL) ?
								hrhp_pkg::KEY_FAIL : key_step;
							scan_n    = hrhp_pkg::H_KEY;
						end
					end
					default: begin
						priority if ((scan_q == hrhp_pkg::H_VALNEED
							|| scan_q == hrhp_pkg::H_VALWS) && hrhp_pkg::is_ws(b)) begin
							scan_n = hrhp_pkg::H_VALWS;
						end else if ((scan_q == hrhp_pkg::H_VALNEED
							|| scan_q == hrhp_pkg::H_VALWS)
							&& (b == hrhp_pkg::CH_PLUS || b == hrhp_pkg::CH_MINUS)) begin
							neg_n  = (b == hrhp_pkg::CH_MINUS);
							scan_n = hrhp_pkg::H_VALSIGN;
						end else if (scan_q == hrhp_pkg::H_VALDONE) begin
							scan_n = hrhp_pkg::H_VALDONE;
						end else if (hrhp_pkg::is_digit(b)) begin
							accum_n = (accum_x10 > {4'b0, hrhp_pkg::LEN_MAX}) ?
								hrhp_pkg::LEN_MAX : accum_x10[LB-1:0];
							scan_n  = hrhp_pkg::H_VALDIG;
						end else begin
							scan_n = hrhp_pkg::H_VALDONE;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= hrhp_pkg::PH_REQ;
			fault_q     <= 2'd0;
			scan_q      <= 4'd0;
			scan_prev_q <= 4'd0;
			prev_cr_q   <= 1'b0;
			key_pos_q   <= 5'd0;
			accum_q     <= '0;
			neg_q       <= 1'b0;
			length_q    <= '0;
			body_cnt_q  <= '0;
		end else if (step_en) begin
			phase_q     <= phase_n;
			fault_q     <= fault_n;
			scan_q      <= scan_n;
			scan_prev_q <= scan_prev_n;
			prev_cr_q   <= prev_cr_n;
			key_pos_q   <= key_pos_n;
			accum_q     <= accum_n;
			neg_q       <= neg_n;
			length_q    <= length_n;
			body_cnt_q  <= body_cnt_n;
		end
	end

endmodule

// ===== rtl/core/hrhp_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_out_stage
// Result register: loads a result when the stage is free, holds it while
// the consumer stalls.
// ----------------------------------------------------------------------------
module hrhp_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  hrhp_pkg::result_t result,
	input  logic              out_stall,
	output logic              out_free,
	output logic              out_valid,
	output hrhp_pkg::result_t result_q
);

	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && load) begin
			result_q <= result;
		end
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Byte-level check of the HTTP request head parser against a parser model
// kept inside the bench. Short directed cases come first, then random
// well-formed, broken and truncated requests with random input gaps and
// output stalls, and one stretch with neither.
// ----------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_BODY    = 48;

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          in_valid     = 1'b0;
	logic                          in_stall;
	logic [7:0]                    data_byte    = 8'h00;
	logic                          drop_request = 1'b0;
	logic                          out_valid;
	logic                          out_stall    = 1'b0;
	logic [1:0]                    status;
	logic [1:0]                    phase;
	logic [hrhp_pkg::OUT_BITS-1:0] content_length;
	logic                          body_byte;

	http_request_head_parser dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.drop_request   (drop_request),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.phase          (phase),
		.content_length (content_length),
		.body_byte      (body_byte)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser model state
	hrhp_pkg::phase_t  cur_phase;
	hrhp_pkg::status_t fault;
	logic [3:0]        scan;
	logic [3:0]        scan_prev;
	logic              prev_cr;
	logic [4:0]        key_pos;
	logic [31:0]       accum;
	logic              neg;
	logic [31:0]       len_val;
	logic [31:0]       body_cnt;

	string             length_key = "Content-Length";
	hrhp_pkg::result_t verdict_q[$];
	hrhp_pkg::result_t want;
	logic [7:0]        head_bytes[$];
	int                errors     = 0;
	int                items_sent = 0;
	int                cycles     = 0;
	bit                no_gaps    = 1'b0;

	function automatic bit ws_byte(input logic [7:0] b);
		return b inside {[8'd1:8'd32]};
	endfunction

	function automatic bit sep_byte(input logic [7:0] b);
		return b == hrhp_pkg::CH_SPACE || b == hrhp_pkg::CH_TAB;
	endfunction

	function automatic void new_line();
		scan      = 4'd0;
		scan_prev = 4'd0;
		prev_cr   = 1'b0;
		key_pos   = 5'd0;
		accum     = 32'd0;
		neg       = 1'b0;
	endfunction

	function automatic void clear_request();
		cur_phase = hrhp_pkg::PH_REQ;
		fault     = hrhp_pkg::ST_PENDING;
		new_line();
		len_val   = 32'd0;
		body_cnt  = 32'd0;
	endfunction

	function automatic void match_key(input logic [7:0] b);
		if (key_pos < hrhp_pkg::KEY_LEN && b == 8'(length_key[key_pos]))
			key_pos = key_pos + 5'd1;
		else
			key_pos = hrhp_pkg::KEY_FAIL;
	endfunction

	function automatic logic [3:0] next_req(input logic [3:0] s, input logic [7:0] b);
		case (s)
			hrhp_pkg::R_LEAD:
				return sep_byte(b) ? hrhp_pkg::R_LEAD : hrhp_pkg::R_METHOD;
			hrhp_pkg::R_METHOD:
				return sep_byte(b) ? hrhp_pkg::R_AFTER : hrhp_pkg::R_METHOD;
			hrhp_pkg::R_AFTER, hrhp_pkg::R_SKIP: begin
				if (sep_byte(b))
					return hrhp_pkg::R_SKIP;
				return (b == hrhp_pkg::CH_SLASH) ? hrhp_pkg::R_PATH_OK : hrhp_pkg::R_PATH_BAD;
			end
			hrhp_pkg::R_PATH_OK:
				return hrhp_pkg::R_PATH_OK;
			default:
				return hrhp_pkg::R_PATH_BAD;
		endcase
	endfunction

	function automatic logic [3:0] next_hdr(input logic [3:0] s, input logic [7:0] b);
		logic [63:0] d;
		case (s)
			hrhp_pkg::H_START, hrhp_pkg::H_COLONS: begin
				if (b == hrhp_pkg::CH_COLON)
					return hrhp_pkg::H_COLONS;
				if (ws_byte(b))
					return hrhp_pkg::H_KEYLEAD;
				match_key(b);
				return hrhp_pkg::H_KEY;
			end
			hrhp_pkg::H_KEYLEAD, hrhp_pkg::H_KEY, hrhp_pkg::H_KEYTAIL: begin
				if (b == hrhp_pkg::CH_COLON)
					return hrhp_pkg::H_VALNEED;
				if (ws_byte(b))
					return (s == hrhp_pkg::H_KEYLEAD) ?
						hrhp_pkg::H_KEYLEAD : hrhp_pkg::H_KEYTAIL;
				if (s == hrhp_pkg::H_KEYTAIL)
					key_pos = hrhp_pkg::KEY_FAIL;
				else
					match_key(b);
				return hrhp_pkg::H_KEY;
			end
			default: begin
				if (s == hrhp_pkg::H_VALNEED || s == hrhp_pkg::H_VALWS) begin
					if (ws_byte(b))
						return hrhp_pkg::H_VALWS;
					if (b == hrhp_pkg::CH_PLUS || b == hrhp_pkg::CH_MINUS) begin
						neg = (b == hrhp_pkg::CH_MINUS);
						return hrhp_pkg::H_VALSIGN;
					end
				end
				if (s == hrhp_pkg::H_VALDONE)
					return hrhp_pkg::H_VALDONE;
				if (b >= hrhp_pkg::CH_ZERO && b <= hrhp_pkg::CH_NINE) begin
					d = 64'(b - hrhp_pkg::CH_ZERO);
					if (64'(accum) > (64'(hrhp_pkg::LEN_MAX) - d) / 64'd10)
						accum = hrhp_pkg::LEN_MAX;
					else
						accum = 32'(64'(accum) * 64'd10 + d);
					return hrhp_pkg::H_VALDIG;
				end
				return hrhp_pkg::H_VALDONE;
			end
		endcase
	endfunction

	function automatic hrhp_pkg::result_t parse_byte(input logic [7:0] b, input logic d);
		hrhp_pkg::result_t r;
		r = '0;
		if (d) begin
			clear_request();
			return r;
		end
		r.phase          = cur_phase;
		r.content_length = len_val;
		if (fault != hrhp_pkg::ST_PENDING) begin
			r.status = fault;
			return r;
		end
		if (cur_phase == hrhp_pkg::PH_BODY) begin
			if (body_cnt != hrhp_pkg::LEN_MAX)
				body_cnt = body_cnt + 32'd1;
			r.body_byte = 1'b1;
			if (body_cnt >= len_val) begin
				r.status = hrhp_pkg::ST_COMPLETE;
				r.phase  = hrhp_pkg::PH_REQ;
				clear_request();
			end
			return r;
		end
		if (b == hrhp_pkg::CH_NUL) begin
			fault    = hrhp_pkg::ST_WEDGED;
			r.status = hrhp_pkg::ST_WEDGED;
			return r;
		end
		if (b == hrhp_pkg::CH_LF) begin
			if (!prev_cr)
				fault = hrhp_pkg::ST_MALFORM;
			else if (cur_phase == hrhp_pkg::PH_REQ) begin
				if (scan_prev == hrhp_pkg::R_PATH_OK)
					cur_phase = hrhp_pkg::PH_HDR;
				else
					fault = hrhp_pkg::ST_MALFORM;
			end else if (scan_prev == hrhp_pkg::H_START) begin
				cur_phase = hrhp_pkg::PH_BODY;
				body_cnt  = 32'd0;
			end else if (scan_prev >= hrhp_pkg::H_VALWS
				&& scan_prev <= hrhp_pkg::H_VALDONE) begin
				if (key_pos == hrhp_pkg::KEY_LEN)
					len_val = neg ? 32'd0 : accum;
			end else
				fault = hrhp_pkg::ST_MALFORM;
			r.phase          = cur_phase;
			r.content_length = len_val;
			if (fault != hrhp_pkg::ST_PENDING) begin
				r.status = fault;
				return r;
			end
			new_line();
			if (cur_phase == hrhp_pkg::PH_BODY && len_val == 32'd0) begin
				clear_request();
				r.status = hrhp_pkg::ST_COMPLETE;
				r.phase  = hrhp_pkg::PH_REQ;
			end
			return r;
		end
		scan_prev = scan;
		prev_cr   = (b == hrhp_pkg::CH_CR);
		scan      = (cur_phase == hrhp_pkg::PH_REQ) ? next_req(scan, b) : next_hdr(scan, b);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_v);
		errors++;
		$display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, exp_v);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (verdict_q.size() == 0)
				report_mismatch("result with no byte pending", 32'(status), 32'd0);
			else begin
				want = verdict_q.pop_front();
				if (status !== want.status)
					report_mismatch("status", 32'(status), 32'(want.status));
				if (phase !== want.phase)
					report_mismatch("phase", 32'(phase), 32'(want.phase));
				if (content_length !== want.content_length)
					report_mismatch("content_length", content_length, want.content_length);
				if (body_byte !== want.body_byte)
					report_mismatch("body_byte", 32'(body_byte), 32'(want.body_byte));
			end
		end
		out_stall <= !no_gaps && ($urandom_range(99) < 29);
	end

	task automatic send_item(input logic [7:0] b, input logic d);
		while (!no_gaps && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		data_byte    <= b;
		drop_request <= d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		verdict_q.push_back(parse_byte(b, d));
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(8'(s[i]), 1'b0);
	endtask

	task automatic send_line(input string s);
		send_text(s);
		send_item(hrhp_pkg::CH_CR, 1'b0);
		send_item(hrhp_pkg::CH_LF, 1'b0);
	endtask

	function automatic logic [7:0] pick_sep();
		return $urandom_range(1) ? hrhp_pkg::CH_SPACE : hrhp_pkg::CH_TAB;
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			head_bytes.push_back(8'(s[i]));
	endfunction

	function automatic void push_eol();
		head_bytes.push_back(hrhp_pkg::CH_CR);
		head_bytes.push_back(hrhp_pkg::CH_LF);
	endfunction

	task automatic add_header();
		int kind;
		int v;
		kind = $urandom_range(9);
		if (kind < 6)
			push_text(length_key);
		else if (kind < 8)
			repeat ($urandom_range(1, 8)) head_bytes.push_back(8'($urandom_range(65, 90)));
		else begin
			v = $urandom_range(4);
			if (v == 0)
				head_bytes.push_back(hrhp_pkg::CH_COLON);
			if (v == 1)
				head_bytes.push_back(pick_sep());
			if (v == 3) begin
				push_text("c");
				push_text(length_key.substr(1, 13));
			end else
				push_text(length_key);
			if (v == 2)
				head_bytes.push_back(pick_sep());
			if (v == 4) begin
				head_bytes.push_back(pick_sep());
				push_text("x");
			end
		end
		head_bytes.push_back(hrhp_pkg::CH_COLON);
		repeat ($urandom_range(0, 2)) head_bytes.push_back(pick_sep());
		v = $urandom_range(9);
		if (v == 0)
			head_bytes.push_back(hrhp_pkg::CH_PLUS);
		if (v == 1)
			head_bytes.push_back(hrhp_pkg::CH_MINUS);
		if ($urandom_range(5) == 0)
			push_text("0");
		case ($urandom_range(19))
			0:       push_text("4294967295");
			1:       push_text("4294967296");
			2:       push_text("99999999999999999999");
			3:       ;
			default: push_text($sformatf("%0d", $urandom_range(24)));
		endcase
		if ($urandom_range(7) == 0)
			head_bytes.push_back(8'($urandom_range(33, 126)));
		push_eol();
	endtask

	task automatic build_head(input bit broken);
		int idx;
		head_bytes.delete();
		repeat ($urandom_range(0, 1)) head_bytes.push_back(pick_sep());
		repeat ($urandom_range(1, 6)) head_bytes.push_back(8'($urandom_range(65, 90)));
		repeat ($urandom_range(1, 2)) head_bytes.push_back(pick_sep());
		head_bytes.push_back(hrhp_pkg::CH_SLASH);
		repeat ($urandom_range(0, 6)) head_bytes.push_back(8'($urandom_range(33, 126)));
		if ($urandom_range(1))
			push_text(" HTTP/1.1");
		push_eol();
		repeat ($urandom_range(0, 3)) add_header();
		push_eol();
		if (broken) begin
			idx = $urandom_range(head_bytes.size() - 1);
			case ($urandom_range(4))
				0:       head_bytes[idx] = hrhp_pkg::CH_LF;
				1:       head_bytes[idx] = hrhp_pkg::CH_NUL;
				2:       head_bytes[idx] = hrhp_pkg::CH_COLON;
				3:       head_bytes.delete(idx);
				default: head_bytes[idx] = 8'($urandom_range(255));
			endcase
		end
	endtask

	task automatic send_request();
		int pick;
		int cut;
		pick = $urandom_range(99);
		if (pick < 6) begin
			repeat ($urandom_range(2, 10))
				send_item(8'($urandom_range(255)), $urandom_range(7) == 0);
			send_item(8'($urandom_range(255)), 1'b1);
			return;
		end
		build_head(pick < 30);
		cut = head_bytes.size();
		if (pick >= 30 && pick < 36)
			cut = $urandom_range(head_bytes.size() - 1);
		for (int i = 0; i < cut; i++)
			send_item(head_bytes[i], 1'b0);
		if (cut < head_bytes.size()) begin
			send_item(8'($urandom_range(255)), 1'b1);
			return;
		end
		if (fault != hrhp_pkg::ST_PENDING) begin
			repeat ($urandom_range(1, 3)) send_item(8'($urandom_range(255)), 1'b0);
			send_item(8'($urandom_range(255)), 1'b1);
		end else if (cur_phase == hrhp_pkg::PH_BODY && len_val <= MAX_BODY) begin
			while (cur_phase == hrhp_pkg::PH_BODY)
				send_item(8'($urandom_range(255)), 1'b0);
		end else if (cur_phase != hrhp_pkg::PH_REQ) begin
			repeat ($urandom_range(0, 6)) send_item(8'($urandom_range(255)), 1'b0);
			send_item(8'($urandom_range(255)), 1'b1);
		end
	endtask

	task automatic test_minimal_request();
		send_line("G /");
		send_line("");
	endtask

	task automatic test_bare_line_feed();
		send_item(hrhp_pkg::CH_LF, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'hFF, 1'b1);
	endtask

	task automatic test_zero_byte();
		send_text("G");
		send_item(hrhp_pkg::CH_NUL, 1'b0);
		send_item(8'h80, 1'b0);
		send_item(hrhp_pkg::CH_NUL, 1'b1);
	endtask

	task automatic test_bad_path();
		send_line("G x");
		send_item(8'h7F, 1'b1);
	endtask

	task automatic test_random_requests(input int count);
		int stop;
		stop = items_sent + count;
		while (items_sent < stop)
			send_request();
	endtask

	task automatic test_no_gaps(input int count);
		no_gaps = 1'b1;
		test_random_requests(count);
		no_gaps = 1'b0;
	endtask

	initial begin
		clear_request();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_minimal_request();
		test_bare_line_feed();
		test_zero_byte();
		test_bad_path();
		test_random_requests(450);
		test_no_gaps(250);
		test_random_requests(350);
		in_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/hrhp_pkg.sv
rtl/core/hrhp_in_stage.sv
rtl/core/hrhp_step.sv
rtl/core/hrhp_out_stage.sv
rtl/core/http_request_head_parser.sv
test/tb.sv
